// ===== hw/rtl/dtfm_pkg.sv =====
// Shared constants, types and helpers for the decimal to thousandths parser.
`timescale 1ns / 1ps

package dtfm_pkg;

	localparam int WHOLE_W = 22;
	localparam int FRAC_W  = 10;
	localparam int VALUE_W = 32;

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [WHOLE_W-1:0] WHOLE_GUARD = 22'd214748;
	localparam logic [3:0]         GUARD_DIGIT = 4'd3;
	localparam logic [1:0]         FRAC_MAX    = 2'd3;
	localparam logic [VALUE_W-1:0] MILLI       = 32'd1000;

	// number state captured at the last beat
	typedef struct packed {
		logic               ok;
		logic               negative;
		logic [WHOLE_W-1:0] whole;
		logic [FRAC_W-1:0]  frac;
	} dtfm_snap_t;

	// weight of a fractional digit by its position after the dot
	function automatic logic [FRAC_W-1:0] frac_term(input logic [3:0] digit,
		input logic [1:0] pos);
		logic [FRAC_W-1:0] d;
		d = FRAC_W'(digit);
		case (pos)
			2'd0:    frac_term = FRAC_W'(d * 10'd100);
			2'd1:    frac_term = FRAC_W'(d * 10'd10);
			2'd2:    frac_term = d;
			default: frac_term = '0;
		endcase
	endfunction

endpackage

// ===== hw/rtl/dtfm_char_acc.sv =====
// Per-character accumulator: sign, dot, integer and fraction digits.
`timescale 1ns / 1ps

module dtfm_char_acc (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          character,
	input  logic                last,
	output dtfm_pkg::dtfm_snap_t snap
);
	import dtfm_pkg::*;

	logic [WHOLE_W-1:0] whole_q, whole_n;
	logic [FRAC_W-1:0]  frac_q, frac_n;
	logic [1:0]         fdig_q, fdig_n;
	logic               start_q, neg_q, dot_q, dseen_q, rej_q;
	logic               neg_n, dot_n, dseen_n, rej_n;
	logic               is_digit;
	logic [3:0]         digit;

	// ASCII digits carry their value in the low nibble
	assign digit    = character[3:0];
	assign is_digit = (character >= CH_ZERO) && (character <= CH_NINE);

	always_comb begin
		whole_n = whole_q;
		frac_n  = frac_q;
		fdig_n  = fdig_q;
		neg_n   = neg_q;
		dot_n   = dot_q;
		dseen_n = dseen_q;
		rej_n   = rej_q;
		if (!rej_q) begin
			if (start_q && (character == CH_MINUS || character == CH_PLUS)) begin
				neg_n = (character == CH_MINUS);
			end else if (character == CH_DOT && !dot_q) begin
				dot_n = 1'b1;
			end else if (!is_digit) begin
				rej_n = 1'b1;
			end else begin
				dseen_n = 1'b1;
				if (!dot_q) begin
					if (whole_q > WHOLE_GUARD ||
						(whole_q == WHOLE_GUARD && digit > GUARD_DIGIT)) begin
						rej_n = 1'b1;
					end else begin
						whole_n = WHOLE_W'(whole_q * 22'd10) + WHOLE_W'(digit);
					end
				end else begin
					if (fdig_q >= FRAC_MAX) begin
						rej_n = 1'b1;
					end else begin
						frac_n = frac_q + frac_term(digit, fdig_q);
						fdig_n = fdig_q + 2'd1;
					end
				end
			end
		end
	end

	assign snap.ok       = !rej_n && dseen_n;
	assign snap.negative = neg_n;
	assign snap.whole    = whole_n;
	assign snap.frac     = frac_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			whole_q <= '0;
			frac_q  <= '0;
			fdig_q  <= '0;
			start_q <= 1'b1;
			neg_q   <= 1'b0;
			dot_q   <= 1'b0;
			dseen_q <= 1'b0;
			rej_q   <= 1'b0;
		end else if (step) begin
			if (last) begin
				whole_q <= '0;
				frac_q  <= '0;
				fdig_q  <= '0;
				start_q <= 1'b1;
				neg_q   <= 1'b0;
				dot_q   <= 1'b0;
				dseen_q <= 1'b0;
				rej_q   <= 1'b0;
			end else begin
				whole_q <= whole_n;
				frac_q  <= frac_n;
				fdig_q  <= fdig_n;
				start_q <= 1'b0;
				neg_q   <= neg_n;
				dot_q   <= dot_n;
				dseen_q <= dseen_n;
				rej_q   <= rej_n;
			end
		end
	end

endmodule

// ===== hw/rtl/decimal_to_fixed_milli_parser.sv =====
// Top level: decimal text stream to signed thousandths.
`timescale 1ns / 1ps

// Usage:
//   Slave channel takes one ASCII character per beat in s_axis_tdata, with
//   s_axis_tlast high on the final character of a number. Characters that
//   are not last give no output beat.
//   Master channel gives one beat per number: m_axis_tuser is the valid flag,
//   m_axis_tdata the signed value in thousandths (zero when not valid).
// Throughput: one character per cycle, except while a last character waits in the input register during a stall.
// Path: the beat of a last character lands in the input register, the
//   accumulator result then moves to the scaling stage, and the scaled
//   value moves to the output register.
// Reset: clears the accumulator to the start of a number and empties all
//   stages; s_axis_tready is high right after reset.
// Stall: while m_axis_tready is low the output register holds its beat;
//   non-last characters keep flowing into the accumulator, and a last
//   character waits in the input register only once the scaling stage
//   and the output register are both full.
module decimal_to_fixed_milli_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] character
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [31:0] value
	output logic        m_axis_tuser   // [0] valid_res
);
	import dtfm_pkg::*;

	logic         vld_s1, last_s1;
	logic [7:0]   char_s1;
	logic         vld_s2;
	dtfm_snap_t   snap_s2;
	dtfm_snap_t   snap;
	logic         out_vld_q, out_ok_q;
	logic [31:0]  out_val_q;
	logic         out_free, s2_free, s1_step;
	logic [VALUE_W-1:0] mag;
	logic         ok;
	logic [VALUE_W-1:0] value;

	assign out_free      = !out_vld_q || m_axis_tready;
	assign s2_free       = !vld_s2 || out_free;
	assign s1_step       = vld_s1 && (!last_s1 || s2_free);
	assign s_axis_tready = !vld_s1 || s1_step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	dtfm_char_acc u_acc (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (s1_step),
		.character (char_s1),
		.last      (last_s1),
		.snap      (snap)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (s2_free) begin
			vld_s2 <= s1_step && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && s1_step && last_s1) begin
			snap_s2 <= snap;
		end
	end

	// scale to thousandths; whole part is at most 2147483 so mag fits 32 bits
	assign mag   = VALUE_W'(snap_s2.whole * MILLI) + VALUE_W'(snap_s2.frac);
	assign ok    = snap_s2.ok && !mag[VALUE_W-1];
	assign value = !ok ? '0 : (snap_s2.negative ? (~mag + 32'd1) : mag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && vld_s2) begin
			out_ok_q  <= ok;
			out_val_q <= value;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_val_q;
	assign m_axis_tuser  = out_ok_q;

endmodule
